/* hw/rtl/sds_pkg.sv */
// sds_pkg: shared types for the saturating signed divider
// no dependencies; imported by every module of the divider

package sds_pkg;

    typedef struct packed {
        logic neg;
        logic zero;
    } sds_flags_t;

endpackage

/* hw/rtl/sds_prep.sv */
// sds_prep: input stage, takes operand magnitudes, quotient sign and zero divisor flag
// depends on sds_pkg

module sds_prep #(
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [WIDTH-1:0]         a,
    input  logic [WIDTH-1:0]         b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WIDTH-1:0]         num,
    output logic [WIDTH-1:0]         den,
    output sds_pkg::sds_flags_t      flags
);
    import sds_pkg::*;

    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

    logic                valid_reg;
    logic                valid_next;
    logic [WIDTH-1:0]    num_reg;
    logic [WIDTH-1:0]    num_next;
    logic [WIDTH-1:0]    den_reg;
    logic [WIDTH-1:0]    den_next;
    sds_flags_t          flags_reg;
    sds_flags_t          flags_next;
    logic                load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next      = in_ready ? in_valid : valid_reg;
        num_next        = a[WIDTH-1] ? (~a + ONE) : a;
        den_next        = b[WIDTH-1] ? (~b + ONE) : b;
        flags_next.neg  = a[WIDTH-1] ^ b[WIDTH-1];
        flags_next.zero = (b == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg   <= num_next;
            den_reg   <= den_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign flags     = flags_reg;

endmodule

/* hw/rtl/sds_cell.sv */
// sds_cell: one restoring divide step, yields one quotient bit per item
// depends on sds_pkg

module sds_cell #(
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [WIDTH-1:0]         rem_in,
    input  logic [WIDTH-1:0]         num_in,
    input  logic [WIDTH-1:0]         den_in,
    input  sds_pkg::sds_flags_t      flags_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WIDTH-1:0]         rem_out,
    output logic [WIDTH-1:0]         num_out,
    output logic [WIDTH-1:0]         den_out,
    output sds_pkg::sds_flags_t      flags_out
);
    import sds_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [WIDTH-1:0]    rem_reg;
    logic [WIDTH-1:0]    rem_next;
    logic [WIDTH-1:0]    num_reg;
    logic [WIDTH-1:0]    num_next;
    logic [WIDTH-1:0]    den_reg;
    sds_flags_t          flags_reg;
    logic [WIDTH:0]      shifted;
    logic [WIDTH:0]      diff;
    logic                ge;
    logic                load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // shift in the next dividend bit, trial subtract, quotient bit into the low end
    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        shifted    = {rem_in, num_in[WIDTH-1]};
        diff       = shifted - {1'b0, den_in};
        ge         = !diff[WIDTH];
        rem_next   = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        num_next   = {num_in[WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg   <= rem_next;
            num_reg   <= num_next;
            den_reg   <= den_in;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign num_out   = num_reg;
    assign den_out   = den_reg;
    assign flags_out = flags_reg;

endmodule

/* hw/rtl/sds_fix.sv */
// sds_fix: output stage, applies quotient sign, zero divisor and saturation
// depends on sds_pkg

module sds_fix #(
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [WIDTH-1:0]         qmag,
    input  sds_pkg::sds_flags_t      flags,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WIDTH-1:0]         q
);
    import sds_pkg::*;

    localparam logic [WIDTH-1:0] ONE     = {{(WIDTH-1){1'b0}}, 1'b1};
    localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};

    logic                valid_reg;
    logic                valid_next;
    logic [WIDTH-1:0]    q_reg;
    logic [WIDTH-1:0]    q_next;
    logic                load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        if (flags.zero)
        begin
            q_next = '0;
        end
        else if (flags.neg)
        begin
            q_next = ~qmag + ONE;
        end
        else if (qmag[WIDTH-1])
        begin
            q_next = MAX_POS;
        end
        else
        begin
            q_next = qmag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign q         = q_reg;

endmodule

/* hw/rtl/signed_divider_saturating.sv */
// signed_divider_saturating: top level of the pipelined signed divider
// depends on sds_pkg, sds_prep, sds_cell, sds_fix

// Signed divider, quotient truncated toward zero. A zero divisor gives 0 and the
// most negative value divided by -1 saturates to the largest positive value; no
// remainder is produced. One item is accepted per cycle while in_ready is high.
// The stages are one operand stage, a row of DATA_WIDTH restoring subtract cells,
// one quotient bit each, and one sign/saturation output register. Every stage has
// its own valid bit, so empty stages fill up while the output is stalled.

module signed_divider_saturating #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient
);
    import sds_pkg::*;

    logic [DATA_WIDTH-1:0]  rem   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]  num   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]  den   [0:DATA_WIDTH];
    sds_flags_t             flags [0:DATA_WIDTH];
    logic                   valid [0:DATA_WIDTH];
    logic                   ready [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]  q;

    assign rem[0] = '0;

    sds_prep #(
        .WIDTH     (DATA_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a         (dividend),
        .b         (divisor),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .num       (num[0]),
        .den       (den[0]),
        .flags     (flags[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        sds_cell #(
            .WIDTH     (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .rem_in    (rem[i]),
            .num_in    (num[i]),
            .den_in    (den[i]),
            .flags_in  (flags[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .rem_out   (rem[i+1]),
            .num_out   (num[i+1]),
            .den_out   (den[i+1]),
            .flags_out (flags[i+1])
        );
    end

    sds_fix #(
        .WIDTH     (DATA_WIDTH)
    ) u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid[DATA_WIDTH]),
        .in_ready  (ready[DATA_WIDTH]),
        .qmag      (num[DATA_WIDTH]),
        .flags     (flags[DATA_WIDTH]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .q         (q)
    );

    assign quotient = q;

endmodule

/* tb/sv/signed_divider_saturating_tb.sv */
// signed_divider_saturating_tb: self-checking testbench for the pipelined signed divider
// drives random and corner operands through valid/ready with random stalls on both sides
// depends only on signed_divider_saturating and its submodules

`timescale 1ns / 1ps

module signed_divider_saturating_tb;

    localparam int DW = 32;
    localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINUS_ONE = {DW{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [DW-1:0] dividend = '0;
    logic signed [DW-1:0] divisor = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DW-1:0] quotient;

    logic signed [DW-1:0] pending_quotients[$];
    int error_count = 0;
    int rx_stall_pct = 0;
    int hold_cycles = 0;

    signed_divider_saturating #(
        .DATA_WIDTH(DW)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .dividend(dividend),
        .divisor(divisor),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .quotient(quotient)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("signed_divider_saturating verification failed");
        $finish;
    end

    // zero divisor gives 0, else truncating division of magnitudes, then sign fix-up and saturation
    function automatic logic signed [DW-1:0] predict_quotient(
        input logic [DW-1:0] num,
        input logic [DW-1:0] den
    );
        logic [DW-1:0] num_mag;
        logic [DW-1:0] den_mag;
        logic [DW:0] rem;
        logic [DW-1:0] quo;
        logic negative;
        if (den == '0)
        begin
            return '0;
        end
        negative = num[DW-1] ^ den[DW-1];
        num_mag = num[DW-1] ? ~num + 1'b1 : num;
        den_mag = den[DW-1] ? ~den + 1'b1 : den;
        rem = '0;
        quo = '0;
        for (int i = DW - 1; i >= 0; i--)
        begin
            rem = {rem[DW-1:0], num_mag[i]};
            quo = {quo[DW-2:0], 1'b0};
            if (rem >= {1'b0, den_mag})
            begin
                rem = rem - {1'b0, den_mag};
                quo[0] = 1'b1;
            end
        end
        if (negative)
        begin
            return ~quo + 1'b1;
        end
        if (quo > MOST_POS)
        begin
            return MOST_POS;
        end
        return quo;
    endfunction

    function automatic logic signed [DW-1:0] rand_operand();
        logic [DW-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            4, 5:
            begin
                v = v >> $urandom_range(0, DW - 1);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = ~v + 1'b1;
                end
            end
            6, 7:
            begin
                v = $urandom_range(0, 40);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = ~v + 1'b1;
                end
            end
            8:
            begin
                case ($urandom_range(0, 5))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '0;
                    3: v = 1;
                    4: v = MINUS_ONE;
                    default: v = MOST_NEG + 1;
                endcase
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    // checks both handshakes on the same edge, items in before results out
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_quotients.push_back(predict_quotient(dividend, divisor));
            end
            if (out_valid && out_ready)
            begin
                if (pending_quotients.size() == 0)
                begin
                    $error("quotient: unexpected result %0d", quotient);
                    error_count++;
                end
                else if (quotient !== pending_quotients[0])
                begin
                    $error("quotient mismatch: expected %0d, actual %0d",
                           pending_quotients[0], quotient);
                    error_count++;
                    void'(pending_quotients.pop_front());
                end
                else
                begin
                    void'(pending_quotients.pop_front());
                end
            end
        end
    end

    // result side: long hold-offs on request, otherwise random stall bursts
    initial
    begin
        int held;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                held = hold_cycles;
                hold_cycles = 0;
                repeat (held - 1) @(negedge clk);
            end
            else if ($urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
        dividend = a;
        divisor = b;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count, input int gap_pct);
        logic signed [DW-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < gap_pct)
            begin
                in_valid = 1'b0;
                dividend = $urandom;
                divisor = $urandom;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            b = ($urandom_range(0, 99) < 3) ? '0 : rand_operand();
            send_item(rand_operand(), b);
        end
        in_valid = 1'b0;
    endtask

    task automatic test_corner_operands();
        rx_stall_pct = 25;
        send_item(0, 1);
        send_item(0, MINUS_ONE);
        send_item(MOST_POS, 1);
        send_item(MOST_NEG, 1);
        send_item(MOST_NEG, MINUS_ONE);
        send_item(MOST_NEG, MOST_NEG);
        send_item(MOST_POS, MOST_NEG);
        send_item(MOST_NEG, MOST_POS);
        send_item(MOST_POS, MOST_POS);
        send_item(MOST_POS, MINUS_ONE);
        send_item(MINUS_ONE, MOST_NEG);
        send_item(1, MOST_POS);
        send_item(MOST_NEG, 2);
        send_item(MOST_NEG + 1, MINUS_ONE);
        send_item(0, 0);
        send_item(MOST_NEG, 0);
        send_item(MOST_POS, 0);
        send_item(MINUS_ONE, 0);
        send_item(7, 2);
        send_item(-7, 2);
        send_item(7, -2);
        send_item(-7, -2);
        send_item(5, 7);
        send_item(-5, 7);
        in_valid = 1'b0;
    endtask

    task automatic test_random_operands();
        for (int chunk = 0; chunk < 10; chunk++)
        begin
            rx_stall_pct = (chunk % 3) * 20;
            send_random(140, (chunk % 2 == 0) ? 30 : 0);
        end
    endtask

    task automatic test_output_backpressure();
        rx_stall_pct = 0;
        hold_cycles = 200;
        send_random(120, 0);
    endtask

    task automatic test_drain_pause();
        rx_stall_pct = 20;
        send_random(40, 20);
        while (pending_quotients.size() != 0)
        begin
            @(negedge clk);
        end
        send_random(40, 20);
    endtask

    task automatic test_streaming();
        rx_stall_pct = 0;
        send_random(230, 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_corner_operands();
        test_random_operands();
        test_output_backpressure();
        test_drain_pause();
        test_streaming();

        for (int c = 0; c < 5000 && pending_quotients.size() != 0; c++)
        begin
            @(posedge clk);
        end
        repeat (DW + 8) @(posedge clk);
        if (pending_quotients.size() != 0)
        begin
            $error("quotient: %0d expected results never arrived", pending_quotients.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("signed_divider_saturating verification clean");
        end
        else
        begin
            $display("signed_divider_saturating verification failed");
        end
        $finish;
    end

endmodule
